>>> hw/rtl/ipdfp_pkg.sv
// Shared types and constants for the +IPD frame parser.
package ipdfp_pkg;

    localparam int MAX_PAYLOAD   = 512;
    localparam int MAX_LEN_CHARS = 4;

    localparam int ACCUM_W = 14;
    localparam int CHARS_W = 3;
    localparam int COUNT_W = 10;
    localparam int FLEN_W  = 10;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_I     = 7'b0000010,
        ST_P     = 7'b0000100,
        ST_D     = 7'b0001000,
        ST_COMMA = 7'b0010000,
        ST_LEN   = 7'b0100000,
        ST_DATA  = 7'b1000000
    } hdr_state_t;

    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic              payload_last;
        logic [FLEN_W-1:0] frame_length;
        logic              frame_error;
        logic              ready_res;
    } ipdfp_res_t;

endpackage

>>> hw/rtl/ipdfp_framer.sv
// Header framer, length decoder and prompt/OK ready matcher state with per-beat result logic.
module ipdfp_framer
    import ipdfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       op,
    input  logic [7:0] rx_byte,
    output ipdfp_res_t res
);

    hdr_state_t         state_reg, state_next;
    logic [ACCUM_W-1:0] accum_reg, accum_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic               digits_done_reg, digits_done_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ok_armed_reg, ok_armed_next;
    logic               ready_reg, ready_next;

    logic               is_digit;
    logic [ACCUM_W-1:0] accum_step;
    logic [COUNT_W-1:0] count_inc;
    logic               ready_mid;

    always_comb
    begin
        is_digit   = (rx_byte inside {[CH_ZERO:CH_NINE]});
        accum_step = (accum_reg << 3) + (accum_reg << 1) + {{(ACCUM_W-4){1'b0}}, rx_byte[3:0]};
        count_inc  = count_reg + {{(COUNT_W-1){1'b0}}, 1'b1};
    end

    always_comb
    begin
        state_next       = state_reg;
        accum_next       = accum_reg;
        chars_next       = chars_reg;
        digits_done_next = digits_done_reg;
        count_next       = count_reg;
        ok_armed_next    = ok_armed_reg;
        ready_next       = ready_reg;
        ready_mid        = ready_reg;
        res              = '0;

        if (op == OP_CLEAR)
        begin
            ready_next = 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (rx_byte == CH_PLUS)
                        state_next = ST_I;
                end
                ST_I:
                begin
                    state_next = (rx_byte == CH_I) ? ST_P : ST_IDLE;
                end
                ST_P:
                begin
                    state_next = (rx_byte == CH_P) ? ST_D : ST_IDLE;
                end
                ST_D:
                begin
                    state_next = (rx_byte == CH_D) ? ST_COMMA : ST_IDLE;
                end
                ST_COMMA:
                begin
                    if (rx_byte == CH_COMMA)
                    begin
                        state_next       = ST_LEN;
                        accum_next       = '0;
                        chars_next       = '0;
                        digits_done_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_LEN:
                begin
                    if (rx_byte == CH_COLON)
                    begin
                        if (accum_reg == '0 || accum_reg > ACCUM_W'(MAX_PAYLOAD))
                        begin
                            res.frame_error  = 1'b1;
                            state_next       = ST_IDLE;
                            accum_next       = '0;
                            chars_next       = '0;
                            digits_done_next = 1'b0;
                            count_next       = '0;
                        end
                        else
                        begin
                            state_next = ST_DATA;
                            count_next = '0;
                        end
                    end
                    else if (chars_reg >= CHARS_W'(MAX_LEN_CHARS))
                    begin
                        res.frame_error  = 1'b1;
                        state_next       = ST_IDLE;
                        accum_next       = '0;
                        chars_next       = '0;
                        digits_done_next = 1'b0;
                        count_next       = '0;
                    end
                    else
                    begin
                        chars_next = chars_reg + {{(CHARS_W-1){1'b0}}, 1'b1};
                        // only the leading digits build the value
                        if (!digits_done_reg && is_digit)
                            accum_next = accum_step;
                        else
                            digits_done_next = 1'b1;
                    end
                end
                ST_DATA:
                begin
                    res.payload_valid = 1'b1;
                    res.payload_byte  = rx_byte;
                    res.frame_length  = accum_reg[FLEN_W-1:0];
                    count_next        = count_inc;
                    if ({{(ACCUM_W-COUNT_W){1'b0}}, count_inc} == accum_reg)
                    begin
                        res.payload_last = 1'b1;
                        state_next       = ST_IDLE;
                        accum_next       = '0;
                        chars_next       = '0;
                        digits_done_next = 1'b0;
                        count_next       = '0;
                    end
                end
                default:
                begin
                    state_next       = ST_IDLE;
                    accum_next       = '0;
                    chars_next       = '0;
                    digits_done_next = 1'b0;
                    count_next       = '0;
                end
            endcase

            // prompt sets the flag before the OK matcher looks at it
            if (rx_byte == CH_GT)
                ready_mid = 1'b1;
            ready_next = ready_mid;
            if (!ready_mid)
            begin
                if (!ok_armed_reg)
                begin
                    if (rx_byte == CH_O)
                        ok_armed_next = 1'b1;
                end
                else
                begin
                    ok_armed_next = 1'b0;
                    if (rx_byte == CH_K)
                        ready_next = 1'b1;
                end
            end
        end

        res.ready_res = ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            accum_reg       <= '0;
            chars_reg       <= '0;
            digits_done_reg <= 1'b0;
            count_reg       <= '0;
            ok_armed_reg    <= 1'b0;
            ready_reg       <= 1'b0;
        end
        else if (en)
        begin
            state_reg       <= state_next;
            accum_reg       <= accum_next;
            chars_reg       <= chars_next;
            digits_done_reg <= digits_done_next;
            count_reg       <= count_next;
            ok_armed_reg    <= ok_armed_next;
            ready_reg       <= ready_next;
        end
    end

endmodule

>>> hw/rtl/at_ipd_frame_parser.sv
// Top level of the +IPD frame parser: input beat register, framer, result register.
// A beat is registered on input, then its result is registered on the output.
// Throughput: one beat per cycle while the output is not stalled; the framer updates
// once per beat in a single pass. The input register holds one more beat while a
// finished result waits on m_tready. Reset (rst_n low, asynchronous) empties both
// registers, idles the framer and clears the OK matcher and the ready flag.
module at_ipd_frame_parser
    import ipdfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] payload_byte, [17:8] frame_length,
                                   // [18] frame_error, [19] ready_res, [23:20] zero
    output logic        m_tuser,   // [0] payload_valid
    output logic        m_tlast    // payload_last
);

    logic       in_valid_reg, in_valid_next;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    ipdfp_res_t out_res_reg;
    ipdfp_res_t step_res;
    logic       advance;
    logic       s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    ipdfp_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (advance),
        .op      (in_op_reg),
        .rx_byte (in_byte_reg),
        .res     (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.payload_valid;
    assign m_tlast  = out_res_reg.payload_last;
    assign m_tdata  = {4'b0000, out_res_reg.ready_res, out_res_reg.frame_error,
                       out_res_reg.frame_length, out_res_reg.payload_byte};

endmodule

>>> verif/tb_at_ipd_frame_parser.sv
// Self-checking testbench for the +IPD frame parser: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_at_ipd_frame_parser;
    import ipdfp_pkg::*;

    localparam int RANDOM_BEATS = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       typed;     // res below is the expected result for this row
        ipdfp_res_t res;
    } stim_t;

    localparam ipdfp_res_t NO_RES  = '0;
    localparam ipdfp_res_t RDY_RES = '{1'b0, 8'h00, 1'b0, 10'd0, 1'b0, 1'b1};
    localparam ipdfp_res_t ERR_RES = '{1'b0, 8'h00, 1'b0, 10'd0, 1'b1, 1'b0};
    localparam ipdfp_res_t PAY_RES = '{1'b1, 8'hFF, 1'b1, 10'd1, 1'b0, 1'b0};

    localparam logic [7:0] HDR [5] = '{CH_PLUS, CH_I, CH_P, CH_D, CH_COMMA};

    localparam stim_t DIR_TABLE [27] = '{
        '{OP_BYTE,  CH_O,             1'b1, NO_RES},
        '{OP_BYTE,  CH_K,             1'b1, RDY_RES},
        '{OP_CLEAR, 8'hFF,            1'b1, NO_RES},
        '{OP_BYTE,  CH_PLUS,          1'b0, NO_RES},
        '{OP_BYTE,  CH_I,             1'b0, NO_RES},
        '{OP_BYTE,  CH_P,             1'b0, NO_RES},
        '{OP_BYTE,  CH_D,             1'b0, NO_RES},
        '{OP_BYTE,  CH_COMMA,         1'b0, NO_RES},
        '{OP_BYTE,  CH_ZERO + 8'd1,   1'b0, NO_RES},
        '{OP_BYTE,  CH_COLON,         1'b0, NO_RES},
        '{OP_BYTE,  8'hFF,            1'b1, PAY_RES},
        '{OP_BYTE,  CH_PLUS,          1'b0, NO_RES},
        '{OP_BYTE,  CH_I,             1'b0, NO_RES},
        '{OP_BYTE,  CH_P,             1'b0, NO_RES},
        '{OP_BYTE,  CH_D,             1'b0, NO_RES},
        '{OP_BYTE,  CH_COMMA,         1'b0, NO_RES},
        '{OP_BYTE,  CH_ZERO + 8'd5,   1'b0, NO_RES},
        '{OP_BYTE,  CH_ZERO + 8'd1,   1'b0, NO_RES},
        '{OP_BYTE,  CH_ZERO + 8'd3,   1'b0, NO_RES},
        '{OP_BYTE,  CH_COLON,         1'b1, ERR_RES},
        '{OP_BYTE,  CH_PLUS,          1'b0, NO_RES},
        '{OP_BYTE,  CH_I,             1'b0, NO_RES},
        '{OP_BYTE,  CH_P,             1'b0, NO_RES},
        '{OP_BYTE,  CH_D,             1'b0, NO_RES},
        '{OP_BYTE,  CH_COMMA,         1'b0, NO_RES},
        '{OP_BYTE,  CH_COLON,         1'b1, ERR_RES},
        '{OP_BYTE,  CH_GT,            1'b1, RDY_RES}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = OP_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // parser model state
    hdr_state_t          frm_state = ST_IDLE;
    logic [ACCUM_W-1:0]  len_acc = '0;
    logic [CHARS_W-1:0]  len_chars = '0;
    logic                digits_done = 1'b0;
    logic [COUNT_W-1:0]  pay_count = '0;
    logic                ok_armed = 1'b0;
    logic                ready_flag = 1'b0;

    stim_t      stim_q [$];
    ipdfp_res_t result_q [$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         n_results = 0;
    int         n_frames = 0;
    int         n_hdr_err = 0;
    int         n_clears = 0;

    at_ipd_frame_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void frame_reset();
        frm_state   = ST_IDLE;
        len_acc     = '0;
        len_chars   = '0;
        digits_done = 1'b0;
        pay_count   = '0;
    endfunction

    // Advance the parser model by one beat and return the result it produces.
    function automatic ipdfp_res_t parse_step(input logic op, input logic [7:0] c);
        ipdfp_res_t r;
        r = '0;
        if (op == OP_CLEAR)
        begin
            ready_flag = 1'b0;
            n_clears++;
        end
        else
        begin
            case (frm_state)
                ST_IDLE:
                    if (c == CH_PLUS)
                        frm_state = ST_I;
                ST_I:     frm_state = (c == CH_I) ? ST_P : ST_IDLE;
                ST_P:     frm_state = (c == CH_P) ? ST_D : ST_IDLE;
                ST_D:     frm_state = (c == CH_D) ? ST_COMMA : ST_IDLE;
                ST_COMMA:
                    if (c == CH_COMMA)
                    begin
                        frm_state   = ST_LEN;
                        len_acc     = '0;
                        len_chars   = '0;
                        digits_done = 1'b0;
                    end
                    else
                        frm_state = ST_IDLE;
                ST_LEN:
                    if (c == CH_COLON)
                    begin
                        if (len_acc == 0 || len_acc > MAX_PAYLOAD)
                        begin
                            r.frame_error = 1'b1;
                            n_hdr_err++;
                            frame_reset();
                        end
                        else
                        begin
                            frm_state = ST_DATA;
                            pay_count = '0;
                        end
                    end
                    else if (len_chars >= MAX_LEN_CHARS)
                    begin
                        r.frame_error = 1'b1;
                        n_hdr_err++;
                        frame_reset();
                    end
                    else
                    begin
                        len_chars = len_chars + 1'b1;
                        // only the leading run of digits counts toward the length
                        if (!digits_done && c >= CH_ZERO && c <= CH_NINE)
                            len_acc = ACCUM_W'(len_acc * 10 + (c - CH_ZERO));
                        else
                            digits_done = 1'b1;
                    end
                ST_DATA:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    r.frame_length  = len_acc[FLEN_W-1:0];
                    pay_count = pay_count + 1'b1;
                    if (pay_count == len_acc)
                    begin
                        r.payload_last = 1'b1;
                        n_frames++;
                        frame_reset();
                    end
                end
                default: frame_reset();
            endcase

            if (c == CH_GT)
                ready_flag = 1'b1;
            // the OK matcher holds while the flag is set
            if (!ready_flag)
            begin
                if (!ok_armed)
                begin
                    if (c == CH_O)
                        ok_armed = 1'b1;
                end
                else
                begin
                    ok_armed = 1'b0;
                    if (c == CH_K)
                        ready_flag = 1'b1;
                end
            end
        end
        r.ready_res = ready_flag;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(19))
            0:       return CH_GT;
            1:       return CH_O;
            2:       return CH_K;
            3:       return CH_PLUS;
            4:       return CH_COLON;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
        return b;
    endfunction

    task automatic push_beat(input logic op, input logic [7:0] data);
        stim_q.push_back('{op, data, 1'b0, NO_RES});
    endtask

    task automatic push_header();
        foreach (HDR[k])
            push_beat(OP_BYTE, HDR[k]);
    endtask

    // Decimal length text, at most MAX_LEN_CHARS long, with optional leading
    // zeros and a trailing non-digit that the parser must skip.
    task automatic push_length(input int val);
        logic [7:0] txt [$];
        int v;
        v = val;
        do
        begin
            txt.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        while (v > 0);
        while (txt.size() < MAX_LEN_CHARS && $urandom_range(4) == 0)
            txt.push_front(CH_ZERO);
        if (txt.size() < MAX_LEN_CHARS && $urandom_range(4) == 0)
            txt.push_back(pick_non_digit());
        foreach (txt[k])
            push_beat(OP_BYTE, txt[k]);
    endtask

    task automatic build_random(input int target);
        int kind;
        int len;
        int p;
        bit big_done;
        logic [7:0] b;
        big_done = 1'b0;
        while (stim_q.size() < target)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                if (!big_done && stim_q.size() > target / 3)
                begin
                    len = MAX_PAYLOAD;
                    big_done = 1'b1;
                end
                else if ($urandom_range(7) == 0)
                    len = $urandom_range(17, 80);
                else
                    len = $urandom_range(1, 16);
                push_header();
                push_length(len);
                push_beat(OP_BYTE, CH_COLON);
                repeat (len)
                begin
                    if ($urandom_range(39) == 0)
                        push_beat(OP_CLEAR, 8'($urandom_range(255)));
                    push_beat(OP_BYTE, pick_byte());
                end
            end
            else if (kind < 72)
            begin
                case ($urandom_range(5))
                    0:
                    begin
                        // break the header partway through
                        p = $urandom_range(1, 4);
                        for (int k = 0; k < p; k++)
                            push_beat(OP_BYTE, HDR[k]);
                        do
                            b = 8'($urandom_range(255));
                        while (b == HDR[p]);
                        push_beat(OP_BYTE, b);
                    end
                    1:
                    begin
                        push_header();
                        push_beat(OP_BYTE, CH_COLON);
                    end
                    2:
                    begin
                        push_header();
                        push_length(0);
                        push_beat(OP_BYTE, CH_COLON);
                    end
                    3:
                    begin
                        push_header();
                        push_length($urandom_range(MAX_PAYLOAD + 1, 9999));
                        push_beat(OP_BYTE, CH_COLON);
                    end
                    4:
                    begin
                        push_header();
                        repeat ($urandom_range(MAX_LEN_CHARS + 1, MAX_LEN_CHARS + 2))
                            push_beat(OP_BYTE, ($urandom_range(3) != 0) ?
                                CH_ZERO + 8'($urandom_range(9)) : pick_non_digit());
                    end
                    default:
                    begin
                        push_header();
                        push_beat(OP_BYTE, pick_non_digit());
                        repeat ($urandom_range(1, 2))
                            push_beat(OP_BYTE, CH_ZERO + 8'($urandom_range(9)));
                        push_beat(OP_BYTE, CH_COLON);
                    end
                endcase
            end
            else if (kind < 92)
                repeat ($urandom_range(1, 4))
                    push_beat(OP_BYTE, pick_byte());
            else
                push_beat(OP_CLEAR, 8'($urandom_range(255)));
        end
    endtask

    task automatic send_beat(input stim_t beat);
        ipdfp_res_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= beat.op;
        s_tdata  <= beat.data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = parse_step(beat.op, beat.data);
        result_q.push_back(beat.typed ? beat.res : predicted);
    endtask

    task automatic cmp_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, want, got);
        end
    endtask

    // Drive the output stall pattern and check each result beat.
    always @(posedge clk)
    begin : out_monitor
        ipdfp_res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = result_q.pop_front();
                    cmp_field("payload_valid", want.payload_valid, m_tuser);
                    cmp_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                    cmp_field("payload_last", want.payload_last, m_tlast);
                    cmp_field("frame_length", want.frame_length, m_tdata[17:8]);
                    cmp_field("frame_error", want.frame_error, m_tdata[18]);
                    cmp_field("ready_res", want.ready_res, m_tdata[19]);
                    cmp_field("tdata pad", 0, m_tdata[23:20]);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int total;
        foreach (DIR_TABLE[k])
            stim_q.push_back(DIR_TABLE[k]);
        build_random(stim_q.size() + RANDOM_BEATS);
        total = stim_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < total; i++)
        begin
            if (i < total / 3)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 54;
            end
            else if (i < 2 * total / 3)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_beat(stim_q[i]);
        end
        s_tvalid <= 1'b0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats and checked %0d results under three stall patterns.",
                 total, n_results);
        $display("Model saw %0d complete frames, %0d abandoned headers, %0d flag clears.",
                 n_frames, n_hdr_err, n_clears);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
